// File: rtl/gapf_pkg.sv
// shared types and codes of the grid a-star path finder
// no dependencies; imported by the channel interfaces and the top level
package gapf_pkg;

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] dir_type;
   typedef logic [4:0] coord_type;
   typedef logic [3:0] mask_type;
   typedef logic [9:0] step_type;

   // command codes
   localparam cmd_type CMD_WRITE = 2'd0;
   localparam cmd_type CMD_FIND  = 2'd1;
   localparam cmd_type CMD_READ  = 2'd2;

   // status codes
   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_UNREACH = 2'd1;
   localparam status_type STATUS_RANGE   = 2'd2;

   // step directions
   localparam dir_type DIR_N = 2'd0;
   localparam dir_type DIR_E = 2'd1;
   localparam dir_type DIR_S = 2'd2;
   localparam dir_type DIR_W = 2'd3;

   // path store limits and insertion counter width
   localparam int PATH_CAP = 1023;
   localparam int PATH_AW  = 10;
   localparam int LEN_W    = 10;
   localparam int ORDER_W  = 15;

endpackage

// File: rtl/gapf_req_if.sv
// command channel of the grid a-star path finder
// depends on gapf_pkg for the field types
interface gapf_req_if;
   import gapf_pkg::*;

   logic      valid;
   logic      ready;
   cmd_type   command;
   coord_type cell_x;
   coord_type cell_y;
   coord_type goal_x;
   coord_type goal_y;
   mask_type  open_mask;
   step_type  step_index;

   modport source (output valid, command, cell_x, cell_y, goal_x, goal_y, open_mask,
                   step_index, input ready);
   modport sink   (input valid, command, cell_x, cell_y, goal_x, goal_y, open_mask,
                   step_index, output ready);
endinterface

// File: rtl/gapf_rsp_if.sv
// result channel of the grid a-star path finder
// depends on gapf_pkg for the field types
interface gapf_rsp_if;
   import gapf_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   step_type   path_length;
   dir_type    step_dir;

   modport source (output valid, status, path_length, step_dir, input ready);
   modport sink   (input valid, status, path_length, step_dir, output ready);
endinterface

// File: rtl/grid_astar_path_finder.sv
// Grid A* path finder: maze store, heap-based search sequencer, path store.
// Commands arrive on req_bus, one result beat per command leaves on rsp_bus.
// Commands: write a cell's open-side mask, find a path, read one path step.
// After reset the block sweeps the maze store to all walled, one cell per
// cycle; req_bus.ready stays low during the sweep.
// The block takes one command at a time: ready is high only when the
// sequencer is idle and no result beat is waiting on rsp_bus.
// A write answers in the cycle after acceptance; a read first passes
// through S_RDWAIT for the registered path store read. A find clears
// the visited marks, then runs the search on a heap memory with one read
// and one write port: a pop reads the top and the last entry and sifts
// the last entry down one level at a time, a push sifts the new entry up,
// and each expanded cell fetches its mask and cost, tests each side and
// relaxes each open neighbor; the path is then walked back twice.
// A result beat holds in its output register until rsp_bus.ready is high;
// no new command is taken meanwhile.
// Synchronous active-high reset clears control state and restarts the sweep.
module grid_astar_path_finder #(
   parameter int GRID_W = 32,
   parameter int GRID_H = 32
) (
   input logic       clock,
   input logic       reset,
   gapf_req_if.sink   req_bus,
   gapf_rsp_if.source rsp_bus
);
   import gapf_pkg::*;

   localparam int NCELLS   = GRID_W * GRID_H;
   localparam int HEAP_CAP = 4 * NCELLS + 1;
   localparam int XW       = $clog2(GRID_W);
   localparam int YW       = $clog2(GRID_H);
   localparam int IW       = $clog2(NCELLS);
   localparam int CW       = $clog2(NCELLS);
   localparam int LW       = $clog2(NCELLS + 1);
   localparam int HAW      = $clog2(HEAP_CAP + 1);
   localparam int PW       = $clog2(NCELLS + GRID_W + GRID_H);
   localparam int KW       = PW + ORDER_W;
   localparam int EW       = KW + YW + XW;
   localparam int Y_LO     = XW;
   localparam int K_LO     = XW + YW;

   // sequencer states
   localparam logic [4:0] S_INIT   = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_RDWAIT = 5'd2;
   localparam logic [4:0] S_CLR    = 5'd3;
   localparam logic [4:0] S_SEED   = 5'd4;
   localparam logic [4:0] S_POP0   = 5'd5;
   localparam logic [4:0] S_POP1   = 5'd6;
   localparam logic [4:0] S_POP2   = 5'd7;
   localparam logic [4:0] S_SIFT   = 5'd8;
   localparam logic [4:0] S_SIFTL  = 5'd9;
   localparam logic [4:0] S_SIFTR  = 5'd10;
   localparam logic [4:0] S_EXP0   = 5'd11;
   localparam logic [4:0] S_EXP1   = 5'd12;
   localparam logic [4:0] S_DIR    = 5'd13;
   localparam logic [4:0] S_NBR    = 5'd14;
   localparam logic [4:0] S_PUSH   = 5'd15;
   localparam logic [4:0] S_PUSHP  = 5'd16;
   localparam logic [4:0] S_BT0    = 5'd17;
   localparam logic [4:0] S_BT1    = 5'd18;
   localparam logic [4:0] S_BT2    = 5'd19;
   localparam logic [4:0] S_BT3    = 5'd20;

   function automatic logic [IW-1:0] cell_index(input logic [YW-1:0] y,
                                                input logic [XW-1:0] x);
      cell_index = IW'(IW'(y) * IW'(GRID_W)) + IW'(x);
   endfunction

   // memories
   logic [3:0]       open_mem [NCELLS];
   logic [CW:0]      cost_mem [NCELLS];
   logic [1:0]       came_mem [NCELLS];
   logic [EW-1:0]    heap_mem [HEAP_CAP];
   logic [1:0]       path_mem [PATH_CAP];

   // control registers
   logic [4:0]         state_ff, state_in;
   logic [IW-1:0]      sweep_ff, sweep_in;
   logic [HAW-1:0]     count_ff, count_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]   stored_len_ff, stored_len_in;

   // datapath registers
   logic [XW-1:0]      sx_ff, sx_in, gx_ff, gx_in, cx_ff, cx_in, nx_ff, nx_in;
   logic [YW-1:0]      sy_ff, sy_in, gy_ff, gy_in, cy_ff, cy_in, ny_ff, ny_in;
   logic [HAW-1:0]     hi_ff, hi_in;
   logic [EW-1:0]      m_ff, m_in, l_ff, l_in;
   logic [3:0]         mask_ff, mask_in;
   logic [CW-1:0]      ccost_ff, ccost_in;
   dir_type            dir_ff, dir_in, first_dir_ff, first_dir_in;
   logic [LW-1:0]      len_ff, len_in, kidx_ff, kidx_in;
   status_type         rsp_status_ff, rsp_status_in;
   dir_type            rsp_dir_ff, rsp_dir_in;

   // registered memory read data
   logic [3:0]         open_rd_ff;
   logic [CW:0]        cost_rd_ff;
   logic [1:0]         came_rd_ff;
   logic [EW-1:0]      heap_rd_ff;
   logic [1:0]         path_rd_ff;

   // memory controls
   logic               open_we, cost_we, came_we, heap_we, path_we;
   logic [IW-1:0]      open_waddr, cost_waddr, cost_raddr;
   logic [3:0]         open_wdata;
   logic [CW:0]        cost_wdata;
   logic [HAW-1:0]     heap_waddr, heap_raddr;
   logic [EW-1:0]      heap_wdata;
   logic [PATH_AW-1:0] path_waddr;

   // helper signals
   logic               req_ready, req_fire, req_in_grid, goal_in_grid;
   logic [IW-1:0]      cur_idx, dir_idx, nbr_idx, req_idx;
   logic [XW-1:0]      dir_x, back_x, dist_x;
   logic [YW-1:0]      dir_y, back_y, dist_y;
   logic               dir_ok;
   logic [HAW:0]       c_left, c_right;
   logic [HAW-1:0]     par_idx;
   logic               use_right;
   logic [EW-1:0]      pick;
   logic [CW:0]        nc;
   logic [PW-1:0]      prio;
   logic [LW-1:0]      k_prev;

   assign req_ready      = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_bus.ready  = req_ready;
   assign req_fire       = req_bus.valid && req_ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.path_length = stored_len_ff;
   assign rsp_bus.step_dir    = rsp_dir_ff;

   assign req_in_grid  = (int'(req_bus.cell_x) < GRID_W) && (int'(req_bus.cell_y) < GRID_H);
   assign goal_in_grid = (int'(req_bus.goal_x) < GRID_W) && (int'(req_bus.goal_y) < GRID_H);
   assign req_idx = cell_index(YW'(req_bus.cell_y), XW'(req_bus.cell_x));
   assign cur_idx = cell_index(cy_ff, cx_ff);
   assign nbr_idx = cell_index(ny_ff, nx_ff);
   assign dir_idx = cell_index(dir_y, dir_x);
   assign cost_raddr = (state_ff == S_DIR) ? dir_idx : cur_idx;

   // neighbor of the current cell in the direction under test
   always_comb begin
      dir_x  = cx_ff;
      dir_y  = cy_ff;
      dir_ok = 1'b0;
      case (dir_ff)
         DIR_N: begin
            dir_ok = (cy_ff != '0);
            dir_y  = cy_ff - 1'b1;
         end
         DIR_E: begin
            dir_ok = (int'(cx_ff) != GRID_W - 1);
            dir_x  = cx_ff + 1'b1;
         end
         DIR_S: begin
            dir_ok = (int'(cy_ff) != GRID_H - 1);
            dir_y  = cy_ff + 1'b1;
         end
         default: begin
            dir_ok = (cx_ff != '0);
            dir_x  = cx_ff - 1'b1;
         end
      endcase
      dir_ok = dir_ok && mask_ff[dir_ff];
   end

   // predecessor of the current cell along the stored move
   always_comb begin
      back_x = cx_ff;
      back_y = cy_ff;
      case (came_rd_ff)
         DIR_N:   back_y = cy_ff + 1'b1;
         DIR_E:   back_x = cx_ff - 1'b1;
         DIR_S:   back_y = cy_ff - 1'b1;
         default: back_x = cx_ff + 1'b1;
      endcase
   end

   // heap index arithmetic, child pick and push priority
   assign c_left    = {hi_ff, 1'b1};
   assign c_right   = c_left + 1'b1;
   assign par_idx   = HAW'((hi_ff - 1'b1) >> 1);
   assign use_right = (c_right < {1'b0, count_ff})
                      && (heap_rd_ff[EW-1:K_LO] < l_ff[EW-1:K_LO]);
   assign pick      = use_right ? heap_rd_ff : l_ff;
   assign nc        = {1'b0, ccost_ff} + 1'b1;
   assign dist_x    = (nx_ff >= gx_ff) ? nx_ff - gx_ff : gx_ff - nx_ff;
   assign dist_y    = (ny_ff >= gy_ff) ? ny_ff - gy_ff : gy_ff - ny_ff;
   assign prio      = PW'(nc) + PW'(dist_x) + PW'(dist_y);
   assign k_prev    = kidx_ff - 1'b1;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      count_in      = count_ff;
      order_in      = order_ff;
      rsp_valid_in  = rsp_valid_ff;
      stored_len_in = stored_len_ff;
      sx_in = sx_ff; sy_in = sy_ff; gx_in = gx_ff; gy_in = gy_ff;
      cx_in = cx_ff; cy_in = cy_ff; nx_in = nx_ff; ny_in = ny_ff;
      hi_in = hi_ff; m_in = m_ff; l_in = l_ff;
      mask_in = mask_ff; ccost_in = ccost_ff; dir_in = dir_ff;
      first_dir_in = first_dir_ff;
      len_in = len_ff; kidx_in = kidx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_dir_in    = rsp_dir_ff;
      open_we = 1'b0; open_waddr = sweep_ff; open_wdata = '0;
      cost_we = 1'b0; cost_waddr = nbr_idx; cost_wdata = '0;
      came_we = 1'b0;
      heap_we = 1'b0; heap_waddr = hi_ff; heap_wdata = m_ff; heap_raddr = '0;
      path_we = 1'b0; path_waddr = PATH_AW'(k_prev);

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // maze store sweep after reset
         S_INIT: begin
            open_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (int'(sweep_ff) == NCELLS - 1) begin
               state_in = S_IDLE;
            end
         end

         // command decode
         S_IDLE: begin
            if (req_fire) begin
               case (req_bus.command)
                  CMD_FIND: begin
                     if (req_in_grid && goal_in_grid) begin
                        sx_in    = XW'(req_bus.cell_x);
                        sy_in    = YW'(req_bus.cell_y);
                        gx_in    = XW'(req_bus.goal_x);
                        gy_in    = YW'(req_bus.goal_y);
                        sweep_in = '0;
                        state_in = S_CLR;
                     end else begin
                        stored_len_in = '0;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_UNREACH;
                        rsp_dir_in    = DIR_N;
                     end
                  end
                  CMD_READ: begin
                     if (req_bus.step_index < stored_len_ff) begin
                        state_in = S_RDWAIT;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_RANGE;
                        rsp_dir_in    = DIR_N;
                     end
                  end
                  default: begin
                     if (req_bus.command == CMD_WRITE && req_in_grid) begin
                        open_we    = 1'b1;
                        open_waddr = req_idx;
                        open_wdata = req_bus.open_mask;
                     end
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_dir_in    = DIR_N;
                  end
               endcase
            end
         end

         // path step read returns
         S_RDWAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_dir_in    = path_rd_ff;
            state_in      = S_IDLE;
         end

         // clear visited marks
         S_CLR: begin
            cost_we    = 1'b1;
            cost_waddr = sweep_ff;
            sweep_in   = sweep_ff + 1'b1;
            if (int'(sweep_ff) == NCELLS - 1) begin
               state_in = S_SEED;
            end
         end

         // start cell into the frontier
         S_SEED: begin
            cost_we    = 1'b1;
            cost_waddr = cell_index(sy_ff, sx_ff);
            cost_wdata = {1'b1, CW'(0)};
            heap_we    = 1'b1;
            heap_waddr = '0;
            heap_wdata = {KW'(0), sy_ff, sx_ff};
            count_in   = HAW'(1);
            order_in   = ORDER_W'(1);
            state_in   = S_POP0;
         end

         // pop: read the top entry
         S_POP0: begin
            if (count_ff == '0) begin
               stored_len_in = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_UNREACH;
               rsp_dir_in    = DIR_N;
               state_in      = S_IDLE;
            end else begin
               heap_raddr = '0;
               count_in   = count_ff - 1'b1;
               state_in   = S_POP1;
            end
         end

         S_POP1: begin
            cx_in = heap_rd_ff[Y_LO-1:0];
            cy_in = heap_rd_ff[K_LO-1:Y_LO];
            if (heap_rd_ff[Y_LO-1:0] == gx_ff && heap_rd_ff[K_LO-1:Y_LO] == gy_ff) begin
               len_in   = '0;
               state_in = S_BT0;
            end else if (count_ff == '0) begin
               state_in = S_EXP0;
            end else begin
               heap_raddr = count_ff;
               state_in   = S_POP2;
            end
         end

         S_POP2: begin
            m_in     = heap_rd_ff;
            hi_in    = '0;
            state_in = S_SIFT;
         end

         // sift the last entry down from the root
         S_SIFT: begin
            if (c_left >= {1'b0, count_ff}) begin
               heap_we  = 1'b1;
               state_in = S_EXP0;
            end else begin
               heap_raddr = HAW'(c_left);
               state_in   = S_SIFTL;
            end
         end

         S_SIFTL: begin
            l_in       = heap_rd_ff;
            heap_raddr = HAW'(c_right);
            state_in   = S_SIFTR;
         end

         S_SIFTR: begin
            heap_we = 1'b1;
            if (pick[EW-1:K_LO] >= m_ff[EW-1:K_LO]) begin
               state_in = S_EXP0;
            end else begin
               heap_wdata = pick;
               hi_in      = use_right ? HAW'(c_right) : HAW'(c_left);
               state_in   = S_SIFT;
            end
         end

         // fetch mask and cost of the current cell
         S_EXP0: begin
            state_in = S_EXP1;
         end

         S_EXP1: begin
            mask_in  = open_rd_ff;
            ccost_in = cost_rd_ff[CW-1:0];
            dir_in   = DIR_N;
            state_in = S_DIR;
         end

         // test one side
         S_DIR: begin
            if (dir_ok) begin
               nx_in    = dir_x;
               ny_in    = dir_y;
               state_in = S_NBR;
            end else if (dir_ff == DIR_W) begin
               state_in = S_POP0;
            end else begin
               dir_in = dir_ff + 1'b1;
            end
         end

         // relax the neighbor and start a push
         S_NBR: begin
            if (!cost_rd_ff[CW] || nc < {1'b0, cost_rd_ff[CW-1:0]}) begin
               cost_we    = 1'b1;
               cost_wdata = {1'b1, nc[CW-1:0]};
               came_we    = 1'b1;
            end
            if ((!cost_rd_ff[CW] || nc < {1'b0, cost_rd_ff[CW-1:0]})
                && int'(count_ff) < HEAP_CAP) begin
               m_in     = {prio, order_ff, ny_ff, nx_ff};
               hi_in    = count_ff;
               count_in = count_ff + 1'b1;
               order_in = order_ff + 1'b1;
               state_in = S_PUSH;
            end else if (dir_ff == DIR_W) begin
               state_in = S_POP0;
            end else begin
               dir_in   = dir_ff + 1'b1;
               state_in = S_DIR;
            end
         end

         // sift the new entry up
         S_PUSH: begin
            if (hi_ff == '0) begin
               heap_we = 1'b1;
               if (dir_ff == DIR_W) begin
                  state_in = S_POP0;
               end else begin
                  dir_in   = dir_ff + 1'b1;
                  state_in = S_DIR;
               end
            end else begin
               heap_raddr = par_idx;
               state_in   = S_PUSHP;
            end
         end

         S_PUSHP: begin
            heap_we = 1'b1;
            if (heap_rd_ff[EW-1:K_LO] <= m_ff[EW-1:K_LO]) begin
               if (dir_ff == DIR_W) begin
                  state_in = S_POP0;
               end else begin
                  dir_in   = dir_ff + 1'b1;
                  state_in = S_DIR;
               end
            end else begin
               heap_wdata = heap_rd_ff;
               hi_in      = par_idx;
               state_in   = S_PUSH;
            end
         end

         // first walk back: count the steps
         S_BT0: begin
            if ((cx_ff == sx_ff && cy_ff == sy_ff) || int'(len_ff) == NCELLS) begin
               kidx_in  = len_ff;
               cx_in    = gx_ff;
               cy_in    = gy_ff;
               state_in = S_BT2;
            end else begin
               state_in = S_BT1;
            end
         end

         S_BT1: begin
            cx_in    = back_x;
            cy_in    = back_y;
            len_in   = len_ff + 1'b1;
            state_in = S_BT0;
         end

         // second walk back: fill the path store
         S_BT2: begin
            if (kidx_ff == '0) begin
               stored_len_in = (int'(len_ff) >= PATH_CAP) ? LEN_W'(PATH_CAP)
                                                         : LEN_W'(len_ff);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_dir_in    = (len_ff != '0) ? first_dir_ff : DIR_N;
               state_in      = S_IDLE;
            end else begin
               state_in = S_BT3;
            end
         end

         S_BT3: begin
            if (int'(k_prev) < PATH_CAP) begin
               path_we = 1'b1;
            end
            if (k_prev == '0) begin
               first_dir_in = came_rd_ff;
            end
            cx_in    = back_x;
            cy_in    = back_y;
            kidx_in  = k_prev;
            state_in = S_BT2;
         end

         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         sweep_ff      <= '0;
         count_ff      <= '0;
         order_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         stored_len_ff <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         count_ff      <= count_in;
         order_ff      <= order_in;
         rsp_valid_ff  <= rsp_valid_in;
         stored_len_ff <= stored_len_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sx_ff <= sx_in; sy_ff <= sy_in; gx_ff <= gx_in; gy_ff <= gy_in;
      cx_ff <= cx_in; cy_ff <= cy_in; nx_ff <= nx_in; ny_ff <= ny_in;
      hi_ff <= hi_in; m_ff <= m_in; l_ff <= l_in;
      mask_ff <= mask_in; ccost_ff <= ccost_in; dir_ff <= dir_in;
      first_dir_ff <= first_dir_in;
      len_ff <= len_in; kidx_ff <= kidx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dir_ff    <= rsp_dir_in;
   end

   // memories with registered reads
   always_ff @(posedge clock) begin
      if (open_we) begin
         open_mem[open_waddr] <= open_wdata;
      end
      open_rd_ff <= open_mem[cur_idx];
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_waddr] <= cost_wdata;
      end
      cost_rd_ff <= cost_mem[cost_raddr];
   end

   always_ff @(posedge clock) begin
      if (came_we) begin
         came_mem[nbr_idx] <= dir_ff;
      end
      came_rd_ff <= came_mem[cur_idx];
   end

   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[heap_waddr] <= heap_wdata;
      end
      heap_rd_ff <= heap_mem[heap_raddr];
   end

   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[path_waddr] <= came_rd_ff;
      end
      path_rd_ff <= path_mem[PATH_AW'(req_bus.step_index)];
   end

`ifndef NO_ASSERTIONS
   // reset restarts the maze sweep with no beat pending
   assert property (@(posedge clock) reset |=> (state_ff == S_INIT && !rsp_valid_ff))
      else $error("reset did not restart the maze sweep");

   // a pending result beat only sits in the idle state
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> state_ff == S_IDLE)
      else $error("result beat pending outside idle");

   // the frontier never exceeds the heap depth
   assert property (@(posedge clock) disable iff (reset) int'(count_ff) <= HEAP_CAP)
      else $error("frontier count beyond heap depth");

   // sift-down index stays inside the live heap
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == S_SIFT |-> hi_ff < count_ff)
      else $error("sift index outside the heap");

   // an accepted find either starts the clear or answers at once
   assert property (@(posedge clock) disable iff (reset)
                    (req_fire && req_bus.command == CMD_FIND)
                    |=> (state_ff == S_CLR || rsp_valid_ff))
      else $error("find command neither started nor answered");
`endif

endmodule
